// ===== src/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_INS_SETUP,
    OP_INS_READ,
    OP_INS_SHIFT,
    OP_INS_PLACE,
    OP_POP_READ0,
    OP_POP_FRONT,
    OP_POP_READ,
    OP_POP_MOVE,
    OP_POP_DONE,
    OP_FAIL_FULL,
    OP_FAIL_EMPTY
  } dp_op_e;

  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_at_count;
    logic place_here;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/spq_ctrl.sv =====
`default_nettype none
module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire dp_status_t status_i,
  output dp_op_e          op_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHECK,
    S_INS_CMP,
    S_POP_FRONT,
    S_POP_CHECK,
    S_POP_MOVE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_o    = OP_LATCH;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status_i.is_pop) begin
          if (status_i.full) begin
            op_o    = OP_FAIL_FULL;
            state_d = S_IDLE;
          end else begin
            op_o    = OP_INS_SETUP;
            state_d = S_INS_CHECK;
          end
        end else if (status_i.empty) begin
          op_o    = OP_FAIL_EMPTY;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_POP_READ0;
          state_d = S_POP_FRONT;
        end
      end
      S_INS_CHECK: begin
        if (status_i.idx_zero) begin
          op_o    = OP_INS_PLACE;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_INS_READ;
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (status_i.place_here) begin
          op_o    = OP_INS_PLACE;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_INS_SHIFT;
          state_d = S_INS_CHECK;
        end
      end
      S_POP_FRONT: begin
        op_o    = OP_POP_FRONT;
        state_d = S_POP_CHECK;
      end
      S_POP_CHECK: begin
        if (status_i.idx_at_count) begin
          op_o    = OP_POP_DONE;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_POP_READ;
          state_d = S_POP_MOVE;
        end
      end
      S_POP_MOVE: begin
        op_o    = OP_POP_MOVE;
        state_d = S_POP_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ===== src/spq_datapath.sv =====
`default_nettype none
module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 16,
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int AW        = $clog2(CAPACITY)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_op_e                op_i,
  output dp_status_t                 status_o,
  input  wire logic                  req_type_i,
  input  wire logic [DATA_WIDTH-1:0] entry_data_i,
  input  wire logic [PRIO_WIDTH-1:0] entry_priority_i,
  output logic                       result_valid_o,
  output logic [DATA_WIDTH-1:0]      front_data_o,
  output logic                       data_valid_o,
  output logic [1:0]                 status_code_o,
  output logic [CNT_W-1:0]           entry_count_o
);

  logic [PRIO_WIDTH-1:0] prio_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] data_mem [CAPACITY];

  logic                  req_pop_q;
  logic [DATA_WIDTH-1:0] req_data_q;
  logic [PRIO_WIDTH-1:0] req_prio_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      idx_q;
  logic [CNT_W-1:0]      idx_m1;
  logic [PRIO_WIDTH-1:0] rd_prio_q;
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [DATA_WIDTH-1:0] front_q;

  logic                  res_valid_q;
  logic [DATA_WIDTH-1:0] res_data_q;
  logic                  res_dvalid_q;
  logic [1:0]            res_status_q;
  logic [CNT_W-1:0]      res_count_q;

  logic                  mem_we;
  logic [AW-1:0]         wr_addr;
  logic [PRIO_WIDTH-1:0] wr_prio;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  finish;

  assign idx_m1 = idx_q - CNT_W'(1);

  assign status_o.is_pop       = req_pop_q;
  assign status_o.full         = (count_q == CNT_W'(CAPACITY));
  assign status_o.empty        = (count_q == '0);
  assign status_o.idx_zero     = (idx_q == '0);
  assign status_o.idx_at_count = (idx_q == count_q);
  assign status_o.place_here   = !(req_prio_q > rd_prio_q);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_prio = req_prio_q;
    wr_data = req_data_q;
    rd_en   = 1'b0;
    rd_addr = idx_m1[AW-1:0];
    case (op_i)
      OP_INS_READ: begin
        rd_en = 1'b1;
      end
      OP_INS_SHIFT: begin
        mem_we  = 1'b1;
        wr_prio = rd_prio_q;
        wr_data = rd_data_q;
      end
      OP_INS_PLACE: begin
        mem_we = 1'b1;
      end
      OP_POP_READ0: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      OP_POP_READ: begin
        rd_en   = 1'b1;
        rd_addr = idx_q[AW-1:0];
      end
      OP_POP_MOVE: begin
        mem_we  = 1'b1;
        wr_addr = idx_m1[AW-1:0];
        wr_prio = rd_prio_q;
        wr_data = rd_data_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prio_mem[wr_addr] <= wr_prio;
      data_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_prio_q <= prio_mem[rd_addr];
      rd_data_q <= data_mem[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    finish  = 1'b0;
    case (op_i)
      OP_INS_PLACE: begin
        count_d = count_q + CNT_W'(1);
        finish  = 1'b1;
      end
      OP_POP_DONE: begin
        count_d = count_q - CNT_W'(1);
        finish  = 1'b1;
      end
      OP_FAIL_FULL, OP_FAIL_EMPTY: begin
        finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LATCH: begin
        req_pop_q  <= (req_type_i == REQ_POP);
        req_data_q <= entry_data_i;
        req_prio_q <= entry_priority_i;
      end
      OP_INS_SETUP: idx_q <= count_q;
      OP_INS_SHIFT: idx_q <= idx_m1;
      OP_POP_FRONT: begin
        front_q <= rd_data_q;
        idx_q   <= CNT_W'(1);
      end
      OP_POP_MOVE:  idx_q <= idx_q + CNT_W'(1);
      default: begin
      end
    endcase
    if (finish) begin
      res_count_q <= count_d;
      if (op_i == OP_POP_DONE) begin
        res_data_q   <= front_q;
        res_dvalid_q <= 1'b1;
      end else begin
        res_data_q   <= '0;
        res_dvalid_q <= 1'b0;
      end
      case (op_i)
        OP_FAIL_FULL:  res_status_q <= ST_FULL;
        OP_FAIL_EMPTY: res_status_q <= ST_EMPTY;
        default:       res_status_q <= ST_OK;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign front_data_o   = res_data_q;
  assign data_valid_o   = res_dvalid_q;
  assign status_code_o  = res_status_q;
  assign entry_count_o  = res_count_q;

endmodule
`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue: holds up to CAPACITY entries (data word plus priority),
// highest priority first, equal priorities in arrival order.
// Request channel: start with req_type_i (insert or pop), entry_data_i and
// entry_priority_i; a request is taken on a clock edge where start is high
// and busy is low. busy stays high until the result has been formed.
// Result channel: result_valid_o strobes for one cycle with front_data_o,
// data_valid_o, status_o (ok, pop on empty, insert on full dropped) and
// entry_count_o. Every request gives exactly one result; the receiver
// cannot stall, so the result must be taken in its strobe cycle.
// Entries live in a single-port-read RAM; each move of an entry is a read
// followed by a write. Insert of an entry that lands behind k held entries
// moves n-k entries; a pop moves the n-1 remaining entries forward.
// Full-insert and empty-pop move no entries. The longest request is a pop
// of a full queue.
// A new request can be accepted in the cycle the previous result strobes.
// Reset clears the count (queue empty) and the controller; RAM contents are
// not cleared, only entries below the count are ever read.
`default_nettype none
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 16,
  localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  req_type_i,
  input  wire logic [DATA_WIDTH-1:0] entry_data_i,
  input  wire logic [PRIO_WIDTH-1:0] entry_priority_i,
  output logic                       result_valid_o,
  output logic [DATA_WIDTH-1:0]      front_data_o,
  output logic                       data_valid_o,
  output logic [1:0]                 status_o,
  output logic [CNT_W-1:0]           entry_count_o
);

  dp_op_e     op;
  dp_status_t dp_status;
  logic       accept;

  assign accept = start && !busy;

  spq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (accept),
    .busy     (busy),
    .status_i (dp_status),
    .op_o     (op)
  );

  spq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .status_o         (dp_status),
    .req_type_i       (req_type_i),
    .entry_data_i     (entry_data_i),
    .entry_priority_i (entry_priority_i),
    .result_valid_o   (result_valid_o),
    .front_data_o     (front_data_o),
    .data_valid_o     (data_valid_o),
    .status_code_o    (status_o),
    .entry_count_o    (entry_count_o)
  );

endmodule
`default_nettype wire

// ===== src/spq_checker.sv =====
`default_nettype none
module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             result_valid_o,
  input wire logic             data_valid_o,
  input wire logic [1:0]       status_o,
  input wire logic [CNT_W-1:0] entry_count_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but busy not raised");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && data_valid_o |-> status_o == ST_OK)
    else $error("popped data with error status");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_FULL |-> entry_count_o == CNT_W'(CAPACITY))
    else $error("full status with queue not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_EMPTY |-> entry_count_o == '0 && !data_valid_o)
    else $error("empty status with entries or data");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .data_valid_o   (data_valid_o),
  .status_o       (status_o),
  .entry_count_o  (entry_count_o)
);
`default_nettype wire

// ===== tb/spq_order_checker.sv =====
`timescale 1ns / 1ps
module spq_order_checker
  import spq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic        req_type_i,
  input  wire logic [31:0] entry_data_i,
  input  wire logic [15:0] entry_priority_i,
  input  wire logic        result_valid_i,
  input  wire logic [31:0] front_data_i,
  input  wire logic        data_valid_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [4:0]  entry_count_i,
  output int               mismatch_cnt_o,
  output int               due_cnt_o
);

  localparam int CAPACITY = 16;

  typedef struct packed {
    logic [31:0] data;
    logic        valid;
    logic [1:0]  status;
    logic [4:0]  count;
  } answer_t;

  logic [15:0] prio_q [CAPACITY];
  logic [31:0] data_q [CAPACITY];
  int          held;
  answer_t     answers_due [$];

  function automatic answer_t predict_answer(input logic kind, input logic [31:0] d,
                                             input logic [15:0] p);
    answer_t a;
    int      pos;
    a = '0;
    a.status = ST_OK;
    if (kind == REQ_INSERT) begin
      if (held >= CAPACITY) begin
        a.status = ST_FULL;
      end else begin
        pos = held;
        for (int i = 0; i < held; i++) begin
          if (p > prio_q[i]) begin
            pos = i;
            break;
          end
        end
        for (int i = held; i > pos; i--) begin
          prio_q[i] = prio_q[i-1];
          data_q[i] = data_q[i-1];
        end
        prio_q[pos] = p;
        data_q[pos] = d;
        held++;
      end
    end else begin
      if (held == 0) begin
        a.status = ST_EMPTY;
      end else begin
        a.data  = data_q[0];
        a.valid = 1'b1;
        for (int i = 1; i < held; i++) begin
          prio_q[i-1] = prio_q[i];
          data_q[i-1] = data_q[i];
        end
        held--;
      end
    end
    a.count = held[4:0];
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      held = 0;
      answers_due.delete();
      mismatch_cnt_o = 0;
      due_cnt_o = 0;
    end else begin
      if (result_valid_i) begin
        got = {front_data_i, data_valid_i, status_i, entry_count_i};
        if (answers_due.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("%0t: result with no request pending: data %h valid %b st %0d cnt %0d",
                     $realtime, got.data, got.valid, got.status, got.count);
          mismatch_cnt_o++;
        end else begin
          want = answers_due.pop_front();
          if (got.data !== want.data || got.valid !== want.valid ||
              got.status !== want.status || got.count !== want.count) begin
            if (mismatch_cnt_o < 10)
              $display("%0t: exp %h v%b st%0d cnt%0d, got %h v%b st%0d cnt%0d",
                       $realtime, want.data, want.valid, want.status, want.count,
                       got.data, got.valid, got.status, got.count);
            mismatch_cnt_o++;
          end
        end
      end
      if (start_i && !busy_i)
        answers_due.push_back(predict_answer(req_type_i, entry_data_i, entry_priority_i));
      due_cnt_o = answers_due.size();
    end
  end

endmodule

// ===== tb/sorted_priority_queue_test.sv =====
`timescale 1ns / 1ps
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int ITEMS   = 1250;
  localparam int LATENCY = 40;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [31:0] entry_data;
  logic [15:0] entry_priority;
  logic        result_valid;
  logic [31:0] front_data;
  logic        data_valid;
  logic [1:0]  status;
  logic [4:0]  entry_count;
  int          mismatch_cnt;
  int          due_cnt;

  sorted_priority_queue dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type),
    .entry_data_i     (entry_data),
    .entry_priority_i (entry_priority),
    .result_valid_o   (result_valid),
    .front_data_o     (front_data),
    .data_valid_o     (data_valid),
    .status_o         (status),
    .entry_count_o    (entry_count)
  );

  spq_order_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .req_type_i       (req_type),
    .entry_data_i     (entry_data),
    .entry_priority_i (entry_priority),
    .result_valid_i   (result_valid),
    .front_data_i     (front_data),
    .data_valid_i     (data_valid),
    .status_i         (status),
    .entry_count_i    (entry_count),
    .mismatch_cnt_o   (mismatch_cnt),
    .due_cnt_o        (due_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // start stays high across back-to-back requests
  task automatic issue(input logic kind, input logic [31:0] d, input logic [15:0] p);
    @(negedge clk);
    start          <= 1'b1;
    req_type       <= kind;
    entry_data     <= d;
    entry_priority <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start          <= 1'b0;
      req_type       <= 1'($urandom);
      entry_data     <= $urandom;
      entry_priority <= 16'($urandom);
    end
  endtask

  function automatic logic [15:0] pick_priority();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int burst;
    int pop_pct;
    int guard;
    rst_n          = 1'b0;
    start          = 1'b0;
    req_type       = REQ_INSERT;
    entry_data     = '0;
    entry_priority = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // pop on empty, priority and data extremes, ties, insert on full
    issue(REQ_POP, 32'hFFFF_FFFF, 16'hFFFF);
    issue(REQ_INSERT, 32'h0000_0000, 16'h0000);
    issue(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    for (int i = 0; i < 14; i++)
      issue(REQ_INSERT, $urandom, (i % 3 == 0) ? 16'h8000 : (i % 3 == 1) ? 16'hFFFF : 16'h0000);
    issue(REQ_INSERT, 32'h5A5A_A5A5, 16'hFFFF);
    repeat (5) issue(REQ_POP, $urandom, 16'($urandom));

    sent = 0;
    while (sent < ITEMS) begin
      burst = $urandom_range(1, 12);
      case ($urandom_range(0, 2))
        0:       pop_pct = 20;
        1:       pop_pct = 80;
        default: pop_pct = 50;
      endcase
      repeat (burst) begin
        issue(($urandom_range(0, 99) < pop_pct) ? REQ_POP : REQ_INSERT, $urandom,
              pick_priority());
        sent++;
      end
      if ($urandom_range(0, 3) != 0)
        pause($urandom_range(1, 8));
    end

    pause(1);
    guard = 0;
    while (due_cnt != 0 && guard < 4 * LATENCY) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
